// ----- rtl/stc2_pkg.sv -----
// Shared types and constants of the straight-track chi2 per dof block.
// Used by stc2_ctrl, stc2_dp and straight_track_chi2_per_dof.
`timescale 1ns / 1ps
package stc2_pkg;

	localparam int POS_W           = 24;
	localparam int SLOPE_W         = 18;
	localparam int Z_W             = 16;
	localparam int HIT_COUNT_W     = 5;
	localparam int WEIGHT_W        = 16;
	localparam int SUM_W           = 64;
	localparam int QUO_W           = 32;
	localparam int MAX_TRACK_HITS_DEF = 24;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd256;

	// one quotient bit per step
	localparam int DIV_STEPS = QUO_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		MUL_PX,
		MUL_PY,
		MUL_SX,
		MUL_SY,
		MUL_WLO,
		MUL_WHI
	} mul_sel_t;

	typedef struct packed {
		logic     cap;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     rx_en;
		logic     ry_en;
		logic     sqx_en;
		logic     sq_add;
		logic     lo_en;
		logic     term_en;
		logic     acc_en;
		logic     div_init;
		logic     div_step;
		logic     out_load;
		logic     clr;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic no_dof;
		logic clip;
	} dp_sts_t;

endpackage

// ----- rtl/stc2_ctrl.sv -----
// Controller of the chi2 per dof block: sequences the shared multiplier,
// the accumulate, the divide and the output register. Uses stc2_pkg.
`timescale 1ns / 1ps
module stc2_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  stc2_pkg::dp_sts_t sts,
	output stc2_pkg::dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PX,
		S_PY,
		S_SX,
		S_SY,
		S_SQ,
		S_WLO,
		S_WHI,
		S_TERM,
		S_ACC,
		S_CHK,
		S_DIV,
		S_OUT
	} state_t;

	state_t                          state_q;
	logic [stc2_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                            out_valid_q;
	logic                            load_ok;

	assign load_ok   = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = stc2_pkg::MUL_PX;
		case (state_q)
			S_IDLE: cmd.cap = in_valid;
			S_PX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = stc2_pkg::MUL_PX;
			end
			S_PY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = stc2_pkg::MUL_PY;
				cmd.rx_en   = 1'b1;
			end
			S_SX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = stc2_pkg::MUL_SX;
				cmd.ry_en   = 1'b1;
			end
			S_SY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = stc2_pkg::MUL_SY;
				cmd.sqx_en  = 1'b1;
			end
			S_SQ: cmd.sq_add = 1'b1;
			S_WLO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = stc2_pkg::MUL_WLO;
			end
			S_WHI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = stc2_pkg::MUL_WHI;
				cmd.lo_en   = 1'b1;
			end
			S_TERM: cmd.term_en  = 1'b1;
			S_ACC:  cmd.acc_en   = 1'b1;
			S_CHK:  cmd.div_init = 1'b1;
			S_DIV:  cmd.div_step = 1'b1;
			S_OUT: begin
				cmd.out_load = load_ok;
				cmd.clr      = load_ok;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && load_ok)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_PX;
				S_PX:   state_q <= S_PY;
				S_PY:   state_q <= S_SX;
				S_SX:   state_q <= S_SY;
				S_SY:   state_q <= S_SQ;
				S_SQ:   state_q <= S_WLO;
				S_WLO:  state_q <= S_WHI;
				S_WHI:  state_q <= S_TERM;
				S_TERM: state_q <= S_ACC;
				S_ACC:  state_q <= sts.last ? S_CHK : S_IDLE;
				S_CHK: begin
					cnt_q <= '0;
					if (sts.no_dof || sts.clip)
						state_q <= S_OUT;
					else
						state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == stc2_pkg::DIV_CNT_W'(stc2_pkg::DIV_STEPS - 1))
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (load_ok)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/stc2_dp.sv -----
// Datapath of the chi2 per dof block: input capture, shared multiplier,
// saturating sum, restoring divider and output register. Uses stc2_pkg.
`timescale 1ns / 1ps
module stc2_dp #(
	parameter int MAX_TRACK_HITS = stc2_pkg::MAX_TRACK_HITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  stc2_pkg::dp_cmd_t                      cmd,
	output stc2_pkg::dp_sts_t                      sts,
	input  logic                                   cfg_we,
	input  logic        [stc2_pkg::WEIGHT_W-1:0]    residual_weight,
	input  logic signed [stc2_pkg::POS_W-1:0]       track_x_origin,
	input  logic signed [stc2_pkg::SLOPE_W-1:0]     track_x_slope,
	input  logic signed [stc2_pkg::POS_W-1:0]       track_y_origin,
	input  logic signed [stc2_pkg::SLOPE_W-1:0]     track_y_slope,
	input  logic        [stc2_pkg::HIT_COUNT_W-1:0] track_hit_count,
	input  logic signed [stc2_pkg::POS_W-1:0]       hit_x,
	input  logic signed [stc2_pkg::POS_W-1:0]       hit_y,
	input  logic signed [stc2_pkg::Z_W-1:0]         hit_z,
	input  logic                                   last_hit,
	output logic        [stc2_pkg::QUO_W-1:0]       chi2_per_dof,
	output logic                                   result_valid,
	output logic                                   saturated
);

	localparam int DOF_BITS = $clog2(2 * MAX_TRACK_HITS);
	localparam int CNT_W    = (DOF_BITS > stc2_pkg::HIT_COUNT_W) ? DOF_BITS
	                                                           : stc2_pkg::HIT_COUNT_W;

	// captured beat
	logic signed [23:0] x0_q, y0_q, hx_q, hy_q;
	logic signed [17:0] tx_q, ty_q;
	logic signed [15:0] hz_q;
	logic [stc2_pkg::HIT_COUNT_W-1:0] hits_q;
	logic               last_q;
	logic [stc2_pkg::WEIGHT_W-1:0] w_q;

	logic signed [32:0] mul_a;
	logic signed [27:0] mul_b;
	logic signed [60:0] prod_q;
	logic signed [26:0] rx_q, ry_q;
	logic [54:0]        sq_q;
	logic [47:0]        lo_q;
	logic [62:0]        term_q;
	logic [stc2_pkg::SUM_W-1:0] sum_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   rem_q;
	logic [stc2_pkg::QUO_W-1:0] dvd_q;
	logic               clip_q;

	logic [24:0]        dx_d, dy_d;
	logic [34:0]        rx16, ry16;
	logic [70:0]        term_full;
	logic [64:0]        sum_next;
	logic [CNT_W-1:0]   hits_c, hits_cl, dof;
	logic               no_dof, clip;
	logic [CNT_W:0]     trial;
	logic               qbit;

	assign hits_c  = CNT_W'(hits_q);
	assign hits_cl = (hits_c > CNT_W'(MAX_TRACK_HITS)) ? CNT_W'(MAX_TRACK_HITS) : hits_c;
	assign no_dof  = (hits_cl <= CNT_W'(2));
	assign dof     = (hits_cl << 1) - CNT_W'(4);
	assign clip    = (sum_q[63:32] >= 32'(dof));

	assign sts.last   = last_q;
	assign sts.no_dof = no_dof;
	assign sts.clip   = clip;

	always_comb begin
		case (cmd.mul_sel)
			stc2_pkg::MUL_PX: begin
				mul_a = {{15{tx_q[17]}}, tx_q};
				mul_b = {{12{hz_q[15]}}, hz_q};
			end
			stc2_pkg::MUL_PY: begin
				mul_a = {{15{ty_q[17]}}, ty_q};
				mul_b = {{12{hz_q[15]}}, hz_q};
			end
			stc2_pkg::MUL_SX: begin
				mul_a = {{6{rx_q[26]}}, rx_q};
				mul_b = {rx_q[26], rx_q};
			end
			stc2_pkg::MUL_SY: begin
				mul_a = {{6{ry_q[26]}}, ry_q};
				mul_b = {ry_q[26], ry_q};
			end
			stc2_pkg::MUL_WLO: begin
				mul_a = {1'b0, sq_q[31:0]};
				mul_b = {12'b0, w_q};
			end
			stc2_pkg::MUL_WHI: begin
				mul_a = {10'b0, sq_q[54:32]};
				mul_b = {12'b0, w_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// residual in Q.16, rounded half up to Q.8
	assign dx_d = {x0_q[23], x0_q} - {hx_q[23], hx_q};
	assign dy_d = {y0_q[23], y0_q} - {hy_q[23], hy_q};
	assign rx16 = {{2{dx_d[24]}}, dx_d, 8'b0} + {prod_q[33], prod_q[33:0]} + 35'd128;
	assign ry16 = {{2{dy_d[24]}}, dy_d, 8'b0} + {prod_q[33], prod_q[33:0]} + 35'd128;

	assign term_full = {prod_q[38:0], 32'b0} + {23'b0, lo_q};
	assign sum_next  = {1'b0, sum_q} + {2'b0, term_q};

	assign trial = {rem_q, dvd_q[stc2_pkg::QUO_W-1]};
	assign qbit  = (trial >= {1'b0, dof});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= stc2_pkg::WEIGHT_RST;
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cfg_we)
				w_q <= residual_weight;
			if (cmd.clr) begin
				sum_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.acc_en) begin
				if (sum_next[64]) begin
					sum_q <= '1;
					ovf_q <= 1'b1;
				end else begin
					sum_q <= sum_next[63:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			x0_q   <= track_x_origin;
			tx_q   <= track_x_slope;
			y0_q   <= track_y_origin;
			ty_q   <= track_y_slope;
			hits_q <= track_hit_count;
			hx_q   <= hit_x;
			hy_q   <= hit_y;
			hz_q   <= hit_z;
			last_q <= last_hit;
		end
		if (cmd.mul_en)
			prod_q <= mul_a * mul_b;
		if (cmd.rx_en)
			rx_q <= rx16[34:8];
		if (cmd.ry_en)
			ry_q <= ry16[34:8];
		if (cmd.sqx_en)
			sq_q <= {2'b0, prod_q[52:0]};
		else if (cmd.sq_add)
			sq_q <= sq_q + {2'b0, prod_q[52:0]};
		if (cmd.lo_en)
			lo_q <= prod_q[47:0];
		if (cmd.term_en)
			term_q <= term_full[70:8];
		if (cmd.div_init) begin
			clip_q <= clip;
			rem_q  <= sum_q[32 +: CNT_W];
			dvd_q  <= sum_q[31:0];
		end else if (cmd.div_step) begin
			rem_q <= qbit ? CNT_W'(trial - {1'b0, dof}) : trial[CNT_W-1:0];
			dvd_q <= {dvd_q[stc2_pkg::QUO_W-2:0], qbit};
		end
		if (cmd.out_load) begin
			if (no_dof) begin
				chi2_per_dof <= '0;
				result_valid <= 1'b0;
				saturated    <= 1'b0;
			end else begin
				chi2_per_dof <= clip_q ? '1 : dvd_q;
				result_valid <= 1'b1;
				saturated    <= clip_q || ovf_q;
			end
		end
	end

endmodule

// ----- rtl/straight_track_chi2_per_dof.sv -----
// Straight-line track chi2 per degree of freedom: top level.
// Instantiates stc2_ctrl and stc2_dp; uses stc2_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): one beat per hit, carrying the track
//   origins, slopes and hit count with the hit's x, y, z and a last_hit mark.
//   Output channel (out_valid/out_ready): one beat per track, on its last hit.
//   Config channel (cfg_valid/cfg_ready): writes residual_weight (Q8.8), always
//   ready; write it only while the block is idle.
//   Per hit: no new hit is taken until the previous one is through; the
//   shared multiplier runs six products per hit and the sum add is its own step.
//   Result: on a last hit the divide follows the accumulate and the result
//   goes to the output register (no divide on no dof or a clip); the divide
//   is restoring, one quotient bit per cycle.
//   Reset: sum and overflow cleared, weight back to 1.0, no result pending.
//   Stall: the result waits in the output register; hits are still taken
//   until the next track's result is ready to load, which then holds until
//   out_ready frees the register.
`timescale 1ns / 1ps
module straight_track_chi2_per_dof #(
	parameter int MAX_TRACK_HITS = stc2_pkg::MAX_TRACK_HITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic        [stc2_pkg::WEIGHT_W-1:0]    residual_weight,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [stc2_pkg::POS_W-1:0]       track_x_origin,
	input  logic signed [stc2_pkg::SLOPE_W-1:0]     track_x_slope,
	input  logic signed [stc2_pkg::POS_W-1:0]       track_y_origin,
	input  logic signed [stc2_pkg::SLOPE_W-1:0]     track_y_slope,
	input  logic        [stc2_pkg::HIT_COUNT_W-1:0] track_hit_count,
	input  logic signed [stc2_pkg::POS_W-1:0]       hit_x,
	input  logic signed [stc2_pkg::POS_W-1:0]       hit_y,
	input  logic signed [stc2_pkg::Z_W-1:0]         hit_z,
	input  logic                                   last_hit,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic        [stc2_pkg::QUO_W-1:0]       chi2_per_dof,
	output logic                                   result_valid,
	output logic                                   saturated
);

	stc2_pkg::dp_cmd_t cmd;
	stc2_pkg::dp_sts_t sts;
	logic              cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	stc2_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	stc2_dp #(
		.MAX_TRACK_HITS (MAX_TRACK_HITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.residual_weight (residual_weight),
		.track_x_origin  (track_x_origin),
		.track_x_slope   (track_x_slope),
		.track_y_origin  (track_y_origin),
		.track_y_slope   (track_y_slope),
		.track_hit_count (track_hit_count),
		.hit_x           (hit_x),
		.hit_y           (hit_y),
		.hit_z           (hit_z),
		.last_hit        (last_hit),
		.chi2_per_dof    (chi2_per_dof),
		.result_valid    (result_valid),
		.saturated       (saturated)
	);

endmodule

// ----- verif/tb_top.sv -----
// Testbench for straight_track_chi2_per_dof: a directed hit table, then random tracks;
// results checked against typed rows or a fixed-point chi2 predictor in this file.
// Depends on rtl/stc2_pkg.sv and rtl/straight_track_chi2_per_dof.sv.
`timescale 1ns / 1ps
module tb_top;

	localparam int POS_W              = stc2_pkg::POS_W;
	localparam int SLOPE_W            = stc2_pkg::SLOPE_W;
	localparam int Z_W                = stc2_pkg::Z_W;
	localparam int HIT_COUNT_W        = stc2_pkg::HIT_COUNT_W;
	localparam int WEIGHT_W           = stc2_pkg::WEIGHT_W;
	localparam int SUM_W              = stc2_pkg::SUM_W;
	localparam int QUO_W              = stc2_pkg::QUO_W;
	localparam int MAX_TRACK_HITS_DEF = stc2_pkg::MAX_TRACK_HITS_DEF;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST = stc2_pkg::WEIGHT_RST;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 64;
	localparam int LONG_HOLD = 800;

	typedef struct {
		logic signed [POS_W-1:0]   x0;
		logic signed [SLOPE_W-1:0] tx;
		logic signed [POS_W-1:0]   y0;
		logic signed [SLOPE_W-1:0] ty;
		logic [HIT_COUNT_W-1:0]    cnt;
		logic signed [POS_W-1:0]   hx;
		logic signed [POS_W-1:0]   hy;
		logic signed [Z_W-1:0]     hz;
		logic                      last;
	} hit_t;

	typedef struct {
		logic [QUO_W-1:0] chi2;
		logic             dof_ok;
		logic             sat;
	} result_t;

	typedef struct {
		hit_t    hit;
		bit      typed;
		result_t want;
	} hit_row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [WEIGHT_W-1:0] residual_weight;
	logic in_valid;
	logic in_ready;
	logic signed [POS_W-1:0] track_x_origin;
	logic signed [SLOPE_W-1:0] track_x_slope;
	logic signed [POS_W-1:0] track_y_origin;
	logic signed [SLOPE_W-1:0] track_y_slope;
	logic [HIT_COUNT_W-1:0] track_hit_count;
	logic signed [POS_W-1:0] hit_x;
	logic signed [POS_W-1:0] hit_y;
	logic signed [Z_W-1:0] hit_z;
	logic last_hit;
	logic out_valid;
	logic out_ready;
	logic [QUO_W-1:0] chi2_per_dof;
	logic result_valid;
	logic saturated;

	straight_track_chi2_per_dof DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.residual_weight (residual_weight),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.track_x_origin  (track_x_origin),
		.track_x_slope   (track_x_slope),
		.track_y_origin  (track_y_origin),
		.track_y_slope   (track_y_slope),
		.track_hit_count (track_hit_count),
		.hit_x           (hit_x),
		.hit_y           (hit_y),
		.hit_z           (hit_z),
		.last_hit        (last_hit),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.chi2_per_dof    (chi2_per_dof),
		.result_valid    (result_valid),
		.saturated       (saturated)
	);

	// predictor state
	logic [SUM_W-1:0]    chi2_acc = '0;
	bit                  chi2_acc_sat = 1'b0;
	logic [WEIGHT_W-1:0] weight_q88 = WEIGHT_RST;

	result_t  chi2_expected[$];
	hit_row_t hit_table[$];
	int       errors = 0;
	int       hits_sent = 0;
	int       cycle_count = 0;
	int       burst_left = 0;
	int       gap_max = 8;
	bit       no_gaps = 1'b0;
	bit       hold_req = 1'b0;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic longint resid_q8(longint origin, longint slope, longint z, longint meas);
		longint r16;
		r16 = (origin - meas) * 256 + slope * z;
		return (r16 + 128) >>> 8;
	endfunction

	function automatic void fit_chi2_step(input hit_t h, output bit emit, output result_t r);
		longint dx;
		longint dy;
		logic [63:0] sq;
		logic [63:0] w64;
		logic [63:0] term;
		logic [63:0] dof;
		logic [63:0] quo;
		logic [64:0] wide;
		int hits;
		dx = resid_q8(longint'(h.x0), longint'(h.tx), longint'(h.hz), longint'(h.hx));
		dy = resid_q8(longint'(h.y0), longint'(h.ty), longint'(h.hz), longint'(h.hy));
		sq = dx * dx + dy * dy;
		w64 = {48'd0, weight_q88};
		term = (sq >> 8) * w64 + (((sq & 64'hFF) * w64) >> 8);
		wide = {1'b0, chi2_acc} + {1'b0, term};
		if (wide[64]) begin
			chi2_acc = '1;
			chi2_acc_sat = 1'b1;
		end else begin
			chi2_acc = wide[63:0];
		end
		emit = h.last;
		r.chi2 = '0;
		r.dof_ok = 1'b0;
		r.sat = 1'b0;
		if (!h.last)
			return;
		hits = int'(h.cnt);
		if (hits > MAX_TRACK_HITS_DEF)
			hits = MAX_TRACK_HITS_DEF;
		if (hits > 2) begin
			dof = 64'(2 * hits - 4);
			quo = chi2_acc / dof;
			r.dof_ok = 1'b1;
			if (quo > 64'hFFFF_FFFF) begin
				r.chi2 = '1;
				r.sat = 1'b1;
			end else begin
				r.chi2 = quo[QUO_W-1:0];
				r.sat = chi2_acc_sat;
			end
		end
		chi2_acc = '0;
		chi2_acc_sat = 1'b0;
	endfunction

	task automatic add_row(int x0, int tx, int y0, int ty, int cnt, int hx, int hy, int hz,
			bit last, bit typed, logic [QUO_W-1:0] e_chi2, bit e_ok, bit e_sat);
		hit_row_t row;
		row.hit.x0 = POS_W'(x0);
		row.hit.tx = SLOPE_W'(tx);
		row.hit.y0 = POS_W'(y0);
		row.hit.ty = SLOPE_W'(ty);
		row.hit.cnt = HIT_COUNT_W'(cnt);
		row.hit.hx = POS_W'(hx);
		row.hit.hy = POS_W'(hy);
		row.hit.hz = Z_W'(hz);
		row.hit.last = last;
		row.typed = typed;
		row.want.chi2 = e_chi2;
		row.want.dof_ok = e_ok;
		row.want.sat = e_sat;
		hit_table.push_back(row);
	endtask

	task automatic sender_gap();
		int n;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if (!no_gaps) begin
				n = $urandom_range(1, gap_max);
				in_valid <= 1'b0;
				repeat (n) @(posedge clk);
			end
			burst_left = $urandom_range(0, 12);
		end
	endtask

	task automatic push_hit(input hit_t h, input bit typed, input result_t want);
		bit emit;
		result_t r;
		in_valid <= 1'b1;
		track_x_origin <= h.x0;
		track_x_slope <= h.tx;
		track_y_origin <= h.y0;
		track_y_slope <= h.ty;
		track_hit_count <= h.cnt;
		hit_x <= h.hx;
		hit_y <= h.hy;
		hit_z <= h.hz;
		last_hit <= h.last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		hits_sent++;
		fit_chi2_step(h, emit, r);
		if (emit)
			chi2_expected.push_back(typed ? want : r);
		sender_gap();
	endtask

	task automatic random_track();
		int style;
		int nhits;
		int noise_max;
		int x0;
		int tx;
		int y0;
		int ty;
		int z;
		bit mark_last;
		logic [HIT_COUNT_W-1:0] cnt;
		hit_t h;
		result_t none;
		style = $urandom_range(0, 99);
		if ($urandom_range(0, 9) < 8)
			nhits = $urandom_range(1, 8);
		else
			nhits = $urandom_range(9, 30);
		if ($urandom_range(0, 4) != 0)
			cnt = HIT_COUNT_W'(nhits);
		else
			cnt = HIT_COUNT_W'($urandom_range(0, 31));
		mark_last = ($urandom_range(0, 9) != 0);
		noise_max = (style < 60) ? 256 : 262144;
		x0 = int'($urandom_range(0, 2097152)) - 1048576;
		y0 = int'($urandom_range(0, 2097152)) - 1048576;
		tx = int'($urandom_range(0, 131072)) - 65536;
		ty = int'($urandom_range(0, 131072)) - 65536;
		for (int i = 0; i < nhits; i++) begin
			if (style < 80) begin
				z = int'($urandom_range(0, 4096)) - 2048;
				h.x0 = POS_W'(x0);
				h.tx = SLOPE_W'(tx);
				h.y0 = POS_W'(y0);
				h.ty = SLOPE_W'(ty);
				h.hz = Z_W'(z);
				h.hx = POS_W'(x0 + ((tx * z) >>> 8)
					+ int'($urandom_range(0, 2 * noise_max)) - noise_max);
				h.hy = POS_W'(y0 + ((ty * z) >>> 8)
					+ int'($urandom_range(0, 2 * noise_max)) - noise_max);
			end else begin
				h.x0 = POS_W'($urandom);
				h.tx = SLOPE_W'($urandom);
				h.y0 = POS_W'($urandom);
				h.ty = SLOPE_W'($urandom);
				h.hx = POS_W'($urandom);
				h.hy = POS_W'($urandom);
				h.hz = Z_W'($urandom);
			end
			h.cnt = cnt;
			h.last = mark_last && (i == nhits - 1);
			push_hit(h, 1'b0, none);
		end
	endtask

	task automatic random_hits(int n);
		int target;
		target = hits_sent + n;
		while (hits_sent < target)
			random_track();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (chi2_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_weight(input logic [WEIGHT_W-1:0] w);
		cfg_valid <= 1'b1;
		residual_weight <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		weight_q88 = w;
		cfg_valid <= 1'b0;
	endtask

	// receiver: windows of always-ready, a fixed mask, or coin flips; long hold on request
	initial begin
		int mode;
		logic [31:0] pat;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 2);
				pat = $urandom | 32'h1;
				for (int i = 0; i < 64; i++) begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= pat[i % 32];
						default: out_ready <= ($urandom_range(0, 3) != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (chi2_expected.size() == 0) begin
				$display("%0t: result beat with none expected: chi2 %h valid %b sat %b",
					$time, chi2_per_dof, result_valid, saturated);
				errors++;
			end else begin
				want = chi2_expected.pop_front();
				if (chi2_per_dof !== want.chi2) begin
					$display("%0t: chi2_per_dof expected %h actual %h", $time, want.chi2, chi2_per_dof);
					errors++;
				end
				if (result_valid !== want.dof_ok) begin
					$display("%0t: result_valid expected %b actual %b", $time, want.dof_ok, result_valid);
					errors++;
				end
				if (saturated !== want.sat) begin
					$display("%0t: saturated expected %b actual %b", $time, want.sat, saturated);
					errors++;
				end
			end
		end
	end

	initial begin
		hit_t h;
		result_t none;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		residual_weight = '0;
		in_valid = 1'b0;
		track_x_origin = '0;
		track_x_slope = '0;
		track_y_origin = '0;
		track_y_slope = '0;
		track_hit_count = '0;
		hit_x = '0;
		hit_y = '0;
		hit_z = '0;
		last_hit = 1'b0;

		// no dof, then exact fits and one hit off the line
		add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0);
		add_row(0, 0, 0, 0, 2, 0, 0, 0, 1, 1, 0, 0, 0);
		add_row(0, 0, 0, 0, 3, 0, 0, 0, 1, 1, 0, 1, 0);
		add_row(0, 0, 0, 0, 24, 0, 0, 0, 1, 1, 0, 1, 0);
		add_row(0, 0, 0, 0, 3, -256, 0, 0, 1, 0, 0, 0, 0);
		// half-LSB rounding, both signs, accumulated into one track
		add_row(0, 128, 0, 0, 4, 0, 0, 1, 0, 0, 0, 0, 0);
		add_row(0, -128, 0, 0, 4, 0, 0, 1, 0, 0, 0, 0, 0);
		add_row(0, -129, 0, 0, 4, 0, 0, 1, 0, 0, 0, 0, 0);
		add_row(0, 0, 0, 384, 25, 0, 0, -1, 1, 0, 0, 0, 0);
		add_row(256, 65536, -256, -65536, 31, 0, 0, 5, 1, 0, 0, 0, 0);
		// field extremes
		add_row(8388607, 131071, 8388607, 131071, 31, -8388608, -8388608, 32767, 1,
			1, 32'hFFFF_FFFF, 1, 1);
		add_row(-8388608, -131072, -8388608, -131072, 3, 8388607, 8388607, -32768, 1,
			0, 0, 0, 0);
		add_row(8388607, 131071, 0, 0, 2, -8388608, 0, -32768, 1, 1, 0, 0, 0);
		add_row(5592405, 87381, 5592405, 87381, 21, -5592406, -5592406, 21845, 0, 0, 0, 0, 0);
		add_row(-5592406, -87382, -5592406, -87382, 10, 5592405, 5592405, -21846, 1,
			0, 0, 0, 0);
		add_row(1000, 65536, -1000, 0, 6, 1000, -1000, 0, 0, 0, 0, 0, 0);
		add_row(1000, 65536, -1000, 0, 6, 1256, -1000, 1, 1, 0, 0, 0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_max = 6;
		foreach (hit_table[i])
			push_hit(hit_table[i].hit, hit_table[i].typed, hit_table[i].want);
		drain();

		// max weight; a long track of worst-case hits saturates the sum
		write_weight(16'hFFFF);
		h.x0 = -8388608;
		h.tx = -131072;
		h.y0 = -8388608;
		h.ty = -131072;
		h.hx = 8388607;
		h.hy = 8388607;
		h.hz = 32767;
		h.cnt = 24;
		for (int i = 0; i < 40; i++) begin
			h.last = (i == 39);
			push_hit(h, 1'b0, none);
		end
		random_hits(110);
		drain();

		write_weight(16'h0000);
		no_gaps = 1'b1;
		random_hits(100);
		drain();

		write_weight(16'h0001);
		no_gaps = 1'b0;
		gap_max = 20;
		random_hits(100);
		drain();

		write_weight(WEIGHT_W'($urandom));
		gap_max = 3;
		random_hits(80);
		// receiver holds off while the sender keeps going
		no_gaps = 1'b1;
		hold_req = 1'b1;
		random_hits(80);
		no_gaps = 1'b0;
		random_hits(90);
		drain();

		write_weight(WEIGHT_RST);
		gap_max = 10;
		random_hits(200);
		drain();

		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
